// ===== rtl/core/bal_pkg.sv =====
`default_nettype none

package bal_pkg;

  // Field widths of the item and result beats.
  localparam int CMD_W   = 2;
  localparam int KIND_W  = 2;
  localparam int ADDR_W  = 48;
  localparam int COUNT_W = 8;
  localparam int TICK_W  = 32;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_OBSERVE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  // Address set codes.
  localparam logic [KIND_W-1:0] KIND_ADVERTISER   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACCESS_POINT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PROBE        = 2'd2;

  // Learning period length after reset.
  localparam logic [TICK_W-1:0] BASELINE_TICKS_RESET = 32'd300000;
  localparam logic [TICK_W-1:0] TICK_MAX             = 32'hFFFF_FFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted item and reset the scan
    logic run;     // scan step: issue one table read this cycle while entries remain
    logic commit;  // update state and load the result register
    logic found;   // the scan matched a stored address
  } bal_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;        // the entry compared this cycle matches
    logic scan_done;  // no further read to issue
  } bal_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/bal_if.sv =====
`default_nettype none

// Input item channel.
interface bal_item_if import bal_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [KIND_W-1:0] kind;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output cmd, output kind, output address, input ready);
  modport sink   (input valid, input cmd, input kind, input address, output ready);
endinterface

// Result channel.
interface bal_result_if import bal_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               is_new;
  logic               alert;
  logic               dropped_full;
  logic [COUNT_W-1:0] set_count;
  logic               learning;
  logic [TICK_W-1:0]  ticks_left;

  modport source (output valid, output is_new, output alert, output dropped_full,
                  output set_count, output learning, output ticks_left, input ready);
  modport sink   (input valid, input is_new, input alert, input dropped_full,
                  input set_count, input learning, input ticks_left, output ready);
endinterface

// Configuration write channel for the learning period length.
interface bal_cfg_if import bal_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/baseline_address_learner.sv =====
// Baseline address learner.
// Three append-only sets of 48-bit addresses (advertisers, access points,
// probe senders). Each input beat on in_if carries cmd, kind and address:
// observe looks the address up in the set named by kind and appends it when
// absent and there is room; tick advances the learning period; restart
// empties all sets and starts learning again. Every input beat yields
// exactly one result beat on out_if with the flags, the set's entry count,
// the learning flag and the ticks left in the learning period.
// Search: an observe beat reads the set's entries in order by linear search,
// one read per cycle through the set's single RAM read port, and stops early
// when the address is found; tick and restart beats issue no table read.
// The result sits in an output register, so a new input beat is taken while
// the previous result waits; if the receiver stalls, the next item is held
// at its final step until the register drains. cfg_if writes the learning
// period length and is always ready. Reset empties all sets, starts learning
// with zero elapsed ticks and sets the period to 300000 ticks.
`default_nettype none

module baseline_address_learner import bal_pkg::*; #(
  parameter int ADVERTISER_DEPTH   = 128,
  parameter int ACCESS_POINT_DEPTH = 128,
  parameter int PROBE_DEPTH        = 128
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  bal_item_if.sink     in_if,
  bal_result_if.source out_if,
  bal_cfg_if.sink      cfg_if
);

  bal_cmd_t cmd;
  bal_sts_t sts;

  assign cfg_if.ready = 1'b1;

  bal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bal_datapath #(
    .ADVERTISER_DEPTH   (ADVERTISER_DEPTH),
    .ACCESS_POINT_DEPTH (ACCESS_POINT_DEPTH),
    .PROBE_DEPTH        (PROBE_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_cmd           (in_if.cmd),
    .in_kind          (in_if.kind),
    .in_address       (in_if.address),
    .cfg_we           (cfg_if.valid),
    .cfg_data         (cfg_if.data),
    .res_is_new       (out_if.is_new),
    .res_alert        (out_if.alert),
    .res_dropped_full (out_if.dropped_full),
    .res_set_count    (out_if.set_count),
    .res_learning     (out_if.learning),
    .res_ticks_left   (out_if.ticks_left)
  );

endmodule

`default_nettype wire

// ===== rtl/core/bal_ram.sv =====
`default_nettype none

module bal_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/bal_ctrl.sv =====
`default_nettype none

module bal_ctrl import bal_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire bal_sts_t sts,
  output bal_cmd_t      cmd
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

  state_t state_r, state_nxt;
  logic   found_r, found_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // The result register can take a new beat when empty or being drained.
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.found     = found_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          found_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.run = 1'b1;
        if (sts.hit) begin
          found_nxt = 1'b1;
          state_nxt = ST_FINISH;
        end else if (sts.scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bal_datapath.sv =====
`default_nettype none

module bal_datapath import bal_pkg::*; #(
  parameter int ADVERTISER_DEPTH   = 128,
  parameter int ACCESS_POINT_DEPTH = 128,
  parameter int PROBE_DEPTH        = 128
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bal_cmd_t          cmd,
  output bal_sts_t               sts,
  input  wire logic [CMD_W-1:0]  in_cmd,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [ADDR_W-1:0] in_address,
  input  wire logic              cfg_we,
  input  wire logic [TICK_W-1:0] cfg_data,
  output logic                   res_is_new,
  output logic                   res_alert,
  output logic                   res_dropped_full,
  output logic [COUNT_W-1:0]     res_set_count,
  output logic                   res_learning,
  output logic [TICK_W-1:0]      res_ticks_left
);

  localparam int MAX_AB = (ADVERTISER_DEPTH > ACCESS_POINT_DEPTH) ?
                          ADVERTISER_DEPTH : ACCESS_POINT_DEPTH;
  localparam int MAX_D  = (MAX_AB > PROBE_DEPTH) ? MAX_AB : PROBE_DEPTH;
  localparam int CW     = $clog2(MAX_D + 1);
  localparam int ADV_AW = (ADVERTISER_DEPTH > 1) ? $clog2(ADVERTISER_DEPTH) : 1;
  localparam int AP_AW  = (ACCESS_POINT_DEPTH > 1) ? $clog2(ACCESS_POINT_DEPTH) : 1;
  localparam int PRB_AW = (PROBE_DEPTH > 1) ? $clog2(PROBE_DEPTH) : 1;

  // Captured item.
  logic [CMD_W-1:0]  cmd_r;
  logic [KIND_W-1:0] kind_r;
  logic [ADDR_W-1:0] addr_r;

  // Set state and learning state.
  logic [CW-1:0]     adv_fill_r, adv_fill_nxt;
  logic [CW-1:0]     ap_fill_r, ap_fill_nxt;
  logic [CW-1:0]     prb_fill_r, prb_fill_nxt;
  logic              learning_r, learning_nxt;
  logic [TICK_W-1:0] elapsed_r, elapsed_nxt;
  logic [TICK_W-1:0] baseline_r;

  // Scan state.
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              pend_r, pend_nxt;

  logic [ADDR_W-1:0] adv_rdata, ap_rdata, prb_rdata, sel_rdata;
  logic [CW-1:0]     sel_fill, sel_cap, sel_fill_nxt, scan_n;
  logic              kind_ok, issue, append, dropped;
  logic              adv_we, ap_we, prb_we;
  logic [TICK_W-1:0] elapsed_inc;

  // Selection of the addressed set.
  always_comb begin
    kind_ok   = 1'b1;
    sel_fill  = '0;
    sel_cap   = '0;
    sel_rdata = adv_rdata;
    unique case (kind_r)
      KIND_ADVERTISER: begin
        sel_fill  = adv_fill_r;
        sel_cap   = CW'(ADVERTISER_DEPTH);
        sel_rdata = adv_rdata;
      end
      KIND_ACCESS_POINT: begin
        sel_fill  = ap_fill_r;
        sel_cap   = CW'(ACCESS_POINT_DEPTH);
        sel_rdata = ap_rdata;
      end
      KIND_PROBE: begin
        sel_fill  = prb_fill_r;
        sel_cap   = CW'(PROBE_DEPTH);
        sel_rdata = prb_rdata;
      end
      default: kind_ok = 1'b0;
    endcase
  end

  // Linear search: one read issued per cycle, compared in the cycle after it is issued.
  assign scan_n        = (cmd_r == CMD_OBSERVE && kind_ok) ? sel_fill : '0;
  assign issue         = cmd.run && (idx_r < scan_n);
  assign sts.hit       = cmd.run && pend_r && (sel_rdata == addr_r);
  assign sts.scan_done = !issue;

  always_comb begin
    idx_nxt  = idx_r;
    pend_nxt = issue;
    if (cmd.load) begin
      idx_nxt  = '0;
      pend_nxt = 1'b0;
    end else if (issue) begin
      idx_nxt = idx_r + CW'(1);
    end
  end

  // Outcome of an observe beat.
  assign append  = (cmd_r == CMD_OBSERVE) && kind_ok && !cmd.found && (sel_fill < sel_cap);
  assign dropped = (cmd_r == CMD_OBSERVE) && kind_ok && !cmd.found && !(sel_fill < sel_cap);
  assign adv_we  = cmd.commit && append && (kind_r == KIND_ADVERTISER);
  assign ap_we   = cmd.commit && append && (kind_r == KIND_ACCESS_POINT);
  assign prb_we  = cmd.commit && append && (kind_r == KIND_PROBE);

  assign elapsed_inc = (elapsed_r == TICK_MAX) ? elapsed_r : elapsed_r + TICK_W'(1);

  // State update applied when the beat commits.
  always_comb begin
    adv_fill_nxt = adv_fill_r;
    ap_fill_nxt  = ap_fill_r;
    prb_fill_nxt = prb_fill_r;
    learning_nxt = learning_r;
    elapsed_nxt  = elapsed_r;
    unique case (cmd_r)
      CMD_OBSERVE: begin
        if (adv_we) adv_fill_nxt = adv_fill_r + CW'(1);
        if (ap_we)  ap_fill_nxt  = ap_fill_r + CW'(1);
        if (prb_we) prb_fill_nxt = prb_fill_r + CW'(1);
      end
      CMD_TICK: begin
        if (learning_r) begin
          elapsed_nxt  = elapsed_inc;
          learning_nxt = !(elapsed_inc >= baseline_r);
        end
      end
      CMD_RESTART: begin
        adv_fill_nxt = '0;
        ap_fill_nxt  = '0;
        prb_fill_nxt = '0;
        learning_nxt = 1'b1;
        elapsed_nxt  = '0;
      end
      default: ;
    endcase
  end

  // Fill count of the addressed set after the update.
  always_comb begin
    unique case (kind_r)
      KIND_ADVERTISER:   sel_fill_nxt = adv_fill_nxt;
      KIND_ACCESS_POINT: sel_fill_nxt = ap_fill_nxt;
      KIND_PROBE:        sel_fill_nxt = prb_fill_nxt;
      default:           sel_fill_nxt = '0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adv_fill_r <= '0;
      ap_fill_r  <= '0;
      prb_fill_r <= '0;
      learning_r <= 1'b1;
      elapsed_r  <= '0;
      baseline_r <= BASELINE_TICKS_RESET;
      idx_r      <= '0;
      pend_r     <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      pend_r <= pend_nxt;
      if (cmd.commit) begin
        adv_fill_r <= adv_fill_nxt;
        ap_fill_r  <= ap_fill_nxt;
        prb_fill_r <= prb_fill_nxt;
        learning_r <= learning_nxt;
        elapsed_r  <= elapsed_nxt;
      end
      if (cfg_we) begin
        baseline_r <= cfg_data;
      end
    end
  end

  // Item capture and result register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_cmd;
      kind_r <= in_kind;
      addr_r <= in_address;
    end
    if (cmd.commit) begin
      res_is_new       <= append;
      res_alert        <= append && !learning_r;
      res_dropped_full <= dropped;
      res_set_count    <= COUNT_W'(sel_fill_nxt);
      res_learning     <= learning_nxt;
      res_ticks_left   <= (learning_nxt && elapsed_nxt < baseline_r) ?
                          baseline_r - elapsed_nxt : '0;
    end
  end

  // Address stores, one per set.
  bal_ram #(.WIDTH(ADDR_W), .DEPTH(ADVERTISER_DEPTH)) u_adv_ram (
    .clk   (clk),
    .we    (adv_we),
    .waddr (adv_fill_r[ADV_AW-1:0]),
    .wdata (addr_r),
    .raddr (idx_r[ADV_AW-1:0]),
    .rdata (adv_rdata)
  );

  bal_ram #(.WIDTH(ADDR_W), .DEPTH(ACCESS_POINT_DEPTH)) u_ap_ram (
    .clk   (clk),
    .we    (ap_we),
    .waddr (ap_fill_r[AP_AW-1:0]),
    .wdata (addr_r),
    .raddr (idx_r[AP_AW-1:0]),
    .rdata (ap_rdata)
  );

  bal_ram #(.WIDTH(ADDR_W), .DEPTH(PROBE_DEPTH)) u_prb_ram (
    .clk   (clk),
    .we    (prb_we),
    .waddr (prb_fill_r[PRB_AW-1:0]),
    .wdata (addr_r),
    .raddr (idx_r[PRB_AW-1:0]),
    .rdata (prb_rdata)
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
  import bal_pkg::*;

  // Codes the package leaves out: an ignored command and a kind with no set.
  localparam logic [CMD_W-1:0]  CMD_IGNORED = 2'd3;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

  localparam int NUM_SETS     = 3;
  localparam int SET_DEPTH    = 128;
  localparam int POOL_SIZE    = 64;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT  = 4000;
  localparam int MAX_REPORTS  = 100;

  // Expected content of one result beat.
  typedef struct packed {
    logic               is_new;
    logic               alert;
    logic               dropped_full;
    logic [COUNT_W-1:0] set_count;
    logic               learning;
    logic [TICK_W-1:0]  ticks_left;
  } status_t;

  logic clk = 1'b0;
  logic rst_n;

  bal_item_if   in_ch ();
  bal_result_if out_ch ();
  bal_cfg_if    cfg_ch ();

  baseline_address_learner dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Shadow copy of the address sets, the learning timer and the period register.
  logic [ADDR_W-1:0] stored_addr [NUM_SETS][SET_DEPTH];
  int unsigned       stored_count [NUM_SETS];
  logic              learning_q;
  logic [TICK_W-1:0] elapsed_q;
  logic [TICK_W-1:0] period_q;

  status_t           status_due [$];
  logic [ADDR_W-1:0] addr_pool [$];
  int unsigned       mismatches;
  int unsigned       results_seen;
  bit                steady;

  logic in_fire;
  logic out_fire;
  logic cfg_fire;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;

  always #6 clk = ~clk;

  // Updates the shadow state for one accepted item and returns its status.
  function automatic status_t next_status(input logic [CMD_W-1:0]  c,
                                          input logic [KIND_W-1:0] k,
                                          input logic [ADDR_W-1:0] a);
    status_t     s;
    bit          hit;
    int unsigned i;
    int unsigned n;
    s   = '0;
    hit = 1'b0;
    case (c)
      CMD_OBSERVE: begin
        if (k != KIND_NONE) begin
          n = stored_count[k];
          for (i = 0; i < n; i++)
            if (stored_addr[k][i] == a) hit = 1'b1;
          if (!hit) begin
            if (n < SET_DEPTH) begin
              stored_addr[k][n] = a;
              stored_count[k]   = n + 1;
              s.is_new          = 1'b1;
              s.alert           = !learning_q;
            end else begin
              s.dropped_full = 1'b1;
            end
          end
        end
      end
      CMD_TICK: begin
        // The timer only runs while learning and saturates at the top.
        if (learning_q) begin
          if (elapsed_q != TICK_MAX) elapsed_q = elapsed_q + 1'b1;
          if (elapsed_q >= period_q) learning_q = 1'b0;
        end
      end
      CMD_RESTART: begin
        foreach (stored_count[j]) stored_count[j] = 0;
        learning_q = 1'b1;
        elapsed_q  = '0;
      end
      default: begin
        // An ignored command only reports the status.
      end
    endcase
    if (k != KIND_NONE) s.set_count = COUNT_W'(stored_count[k]);
    s.learning   = learning_q;
    s.ticks_left = (learning_q && elapsed_q < period_q) ? period_q - elapsed_q : '0;
    return s;
  endfunction

  function automatic logic [ADDR_W-1:0] random_address();
    logic [ADDR_W-1:0] a;
    a[ADDR_W-1:32] = 16'($urandom_range(16'hFFFF));
    a[31:0]        = $urandom;
    return a;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] mismatch: %s got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("result beat %0d field %s", results_seen, name), got, want);
  endtask

  // Sends one item beat and records the status it must produce.
  task automatic send_item(input logic [CMD_W-1:0]  c,
                           input logic [KIND_W-1:0] k,
                           input logic [ADDR_W-1:0] a);
    if (!steady)
      while ($urandom_range(99) < 33) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= c;
    in_ch.kind    <= k;
    in_ch.address <= a;
    do @(posedge clk); while (!in_ch.ready);
    status_due.push_back(next_status(c, k, a));
    if (c == CMD_OBSERVE) begin
      addr_pool.push_back(a);
      if (addr_pool.size() > POOL_SIZE) void'(addr_pool.pop_front());
    end
  endtask

  // Stops sending and waits until every expected result beat has arrived.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (status_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the learning period while the block is idle.
  task automatic write_period(input logic [TICK_W-1:0] value);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    period_q = value;
    cfg_ch.valid <= 1'b0;
  endtask

  // Status straight after reset with the default period.
  task automatic test_reset_state();
    send_item(CMD_IGNORED, KIND_ADVERTISER, '0);
    send_item(CMD_TICK, KIND_NONE, '1);
  endtask

  // Appends, repeats, every set, the missing set and a restart.
  task automatic test_observe_basics();
    send_item(CMD_OBSERVE, KIND_ADVERTISER, '0);
    send_item(CMD_OBSERVE, KIND_ADVERTISER, '0);
    send_item(CMD_OBSERVE, KIND_ADVERTISER, '1);
    send_item(CMD_OBSERVE, KIND_ACCESS_POINT, '1);
    send_item(CMD_OBSERVE, KIND_PROBE, 48'hAAAA_AAAA_AAAA);
    send_item(CMD_OBSERVE, KIND_PROBE, 48'h5555_5555_5555);
    send_item(CMD_OBSERVE, KIND_NONE, 48'h0123_4567_89AB);
    send_item(CMD_IGNORED, KIND_PROBE, '0);
    send_item(CMD_RESTART, KIND_ACCESS_POINT, '0);
    send_item(CMD_OBSERVE, KIND_ADVERTISER, '0);
  endtask

  // Zero, largest and shrunk periods, freezing and alerts.
  task automatic test_period_extremes();
    write_period('0);
    send_item(CMD_TICK, KIND_ADVERTISER, '0);
    send_item(CMD_OBSERVE, KIND_ADVERTISER, 48'h8000_0000_0001);
    send_item(CMD_TICK, KIND_PROBE, '0);
    send_item(CMD_RESTART, KIND_NONE, '0);
    write_period(TICK_MAX);
    send_item(CMD_TICK, KIND_ACCESS_POINT, '0);
    // A period at or below the elapsed time reads zero ticks left while learning stays on until the next tick.
    write_period(32'd1);
    send_item(CMD_IGNORED, KIND_ADVERTISER, '0);
    send_item(CMD_TICK, KIND_ADVERTISER, '0);
  endtask

  // Overfills all three sets with mostly fresh addresses.
  task automatic test_set_capacity();
    int i;
    logic [KIND_W-1:0] k;
    write_period(32'd60);
    send_item(CMD_RESTART, KIND_ADVERTISER, '0);
    for (i = 0; i < 480; i++) begin
      k = KIND_W'(i % NUM_SETS);
      if ($urandom_range(9) == 0)
        send_item(CMD_TICK, k, random_address());
      else if ($urandom_range(99) < 95 || addr_pool.size() == 0)
        send_item(CMD_OBSERVE, k, random_address());
      else
        send_item(CMD_OBSERVE, k, addr_pool[$urandom_range(addr_pool.size() - 1)]);
    end
  endtask

  // Mixed traffic: observes with repeats, ticks, restarts and some noise.
  task automatic test_random_traffic(input int count, input logic [TICK_W-1:0] period,
                                     input int fresh_pct, input int restart_pm,
                                     input bit no_idle);
    int i;
    int pick;
    logic [KIND_W-1:0] k;
    write_period(period);
    steady = no_idle;
    send_item(CMD_RESTART, KIND_W'($urandom_range(3)), random_address());
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(999);
      k    = KIND_W'($urandom_range(NUM_SETS - 1));
      if (pick < restart_pm)
        send_item(CMD_RESTART, KIND_W'($urandom_range(3)), random_address());
      else if (pick < restart_pm + 15)
        send_item(CMD_W'($urandom_range(3)), KIND_NONE, random_address());
      else if (pick < restart_pm + 30)
        send_item(CMD_IGNORED, KIND_W'($urandom_range(3)), random_address());
      else if (pick < restart_pm + 230)
        send_item(CMD_TICK, k, random_address());
      else if ($urandom_range(99) < fresh_pct || addr_pool.size() == 0)
        send_item(CMD_OBSERVE, k, random_address());
      else
        send_item(CMD_OBSERVE, k, addr_pool[$urandom_range(addr_pool.size() - 1)]);
    end
    wait_drained();
    steady = 1'b0;
  endtask

  // Result receiver stalls at random except in steady stretches.
  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 33);
  end

  // Each result beat is compared with the oldest expected status.
  always @(posedge clk) begin : check_results
    status_t want;
    if (rst_n && out_fire) begin
      results_seen++;
      if (status_due.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with nothing expected", results_seen),
                        '0, '0);
      end else begin
        want = status_due.pop_front();
        check_field("is_new", 64'(out_ch.is_new), 64'(want.is_new));
        check_field("alert", 64'(out_ch.alert), 64'(want.alert));
        check_field("dropped_full", 64'(out_ch.dropped_full), 64'(want.dropped_full));
        check_field("set_count", 64'(out_ch.set_count), 64'(want.set_count));
        check_field("learning", 64'(out_ch.learning), 64'(want.learning));
        check_field("ticks_left", 64'(out_ch.ticks_left), 64'(want.ticks_left));
      end
    end
  end

  // Ends the run when no beat moves on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (in_fire || out_fire || cfg_fire) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Reset, then the tests in turn, then the verdict.
  initial begin : run_tests
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_OBSERVE;
    in_ch.kind    = KIND_ADVERTISER;
    in_ch.address = '0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    steady        = 1'b0;
    mismatches    = 0;
    results_seen  = 0;
    foreach (stored_count[j]) stored_count[j] = 0;
    learning_q = 1'b1;
    elapsed_q  = '0;
    period_q   = BASELINE_TICKS_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_observe_basics();
    test_period_extremes();
    test_set_capacity();
    test_random_traffic(400, 32'($urandom_range(8, 40)), 50, 3, 1'b0);
    test_random_traffic(300, 32'd1, 70, 5, 1'b1);
    test_random_traffic(250, TICK_MAX, 40, 25, 1'b0);
    test_random_traffic(100, BASELINE_TICKS_RESET, 60, 2, 1'b0);

    wait_drained();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
